[design/group_position_table_core_macros.svh]
// ----------------------------------------------------------------------------
// Group position table: assertion macros
// Shared assertion helpers. Defining ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef GROUP_POSITION_TABLE_CORE_MACROS_SVH
`define GROUP_POSITION_TABLE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define GPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("group position table: check failed");
`define GPT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("group position table: check failed");
`else
`define GPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define GPT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

[design/gpt_pkg.sv]
// ----------------------------------------------------------------------------
// Group position table: package
// Sizes, codes and control structures shared by the table modules.
// ----------------------------------------------------------------------------
package gpt_pkg;

   localparam int NUM_GROUPS        = 8;
   localparam int GROUP_SLOTS       = 8;
   localparam int MEMBERS_PER_GROUP = 7;

   localparam int GROUP_W     = 3;
   localparam int SLOT_W      = 3;
   localparam int ADDR_W      = GROUP_W + SLOT_W;
   localparam int TABLE_DEPTH = 1 << ADDR_W;
   localparam int VALUE_W     = 7;
   localparam int POS_W       = 8;
   localparam int MASK_W      = 64;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [VALUE_W-1:0] PCT_MAX      = 7'd100;
   localparam logic [VALUE_W-1:0] GROUP_EMPTY  = 7'd101;
   localparam logic [VALUE_W-1:0] MEMBER_EMPTY = 7'd102;
   localparam logic signed [POS_W-1:0] POS_NONE = -8'sd1;

   // Highest member slot that takes part in the average.
   localparam int LAST_MEMBER = (MEMBERS_PER_GROUP < GROUP_SLOTS) ?
                                MEMBERS_PER_GROUP : GROUP_SLOTS - 1;
   localparam int SUM_W  = $clog2(LAST_MEMBER * 100 + 1);
   localparam int CNT_W  = $clog2(LAST_MEMBER + 1);
   localparam int STEP_W = $clog2(SUM_W + 1);

   // Register index of the used-member mask.
   localparam logic REG_USED_MASK = 1'b0;

   typedef enum logic [1:0] {
      MODE_SET  = 2'd0,
      MODE_GET  = 2'd1,
      MODE_TAKE = 2'd2
   } mode_type;

   typedef struct packed {
      logic               clear;
      logic               acc;
      logic [VALUE_W-1:0] value;
      logic               start;
   } avg_ctrl_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [VALUE_W-1:0] average;
   } avg_stat_type;

endpackage

[design/group_position_table_core.sv]
// ----------------------------------------------------------------------------
// Group position table core
// Percent positions for eight groups of member slots, with a group average
// in slot 0 of each group and a mask of groups changed since the last take.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports
//  req       in         req_valid/req_ready, mode, group, member, percent
//  rsp       out        rsp_valid/rsp_ready, position_out, group_average,
//                       changed_groups, unsaved
//  csr       in/out     APB-style, one 64-bit register (used-member mask)
//
//  A set that is taken does one table write, seven slot reads through the
//  single RAM read port, and ten divider steps, one per bit of the member
//  sum; with no member counting the divider steps are skipped. One item is
//  in work at a time; req_ready is low meanwhile. A finished result waits
//  in the output register, and the next item is taken while it waits.
//  Reset is synchronous and leaves every slot empty.
//
`include "group_position_table_core_macros.svh"

module group_position_table_core import gpt_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_mode,
   input  logic [GROUP_W-1:0]         req_group,
   input  logic [SLOT_W-1:0]          req_member,
   input  logic [VALUE_W-1:0]         req_percent,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [POS_W-1:0]    rsp_position_out,
   output logic [VALUE_W-1:0]         rsp_group_average,
   output logic [NUM_GROUPS-1:0]      rsp_changed_groups,
   output logic                       rsp_unsaved,

   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [MASK_W-1:0]          csr_pwdata,
   output logic [MASK_W-1:0]          csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_WALK,
      ST_WALK_END,
      ST_DIV_GO,
      ST_DIV,
      ST_GET_RD,
      ST_GET_WAIT,
      ST_AVG_RD,
      ST_AVG_WAIT,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [1:0]               mode_ff, mode_in;
   logic [GROUP_W-1:0]       group_ff, group_in;
   logic [SLOT_W-1:0]        member_ff, member_in;
   logic [VALUE_W-1:0]       pct_ff, pct_in;
   logic [SLOT_W-1:0]        walk_ff, walk_in;
   logic                     acc_pend_ff, acc_pend_in;
   logic [SLOT_W-1:0]        acc_member_ff, acc_member_in;
   logic [MASK_W-1:0]        mask_ff, mask_in;
   logic [NUM_GROUPS-1:0]    dirty_ff, dirty_in;
   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic [VALUE_W-1:0]       avg_ff, avg_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [VALUE_W-1:0]       rsp_avg_ff, rsp_avg_in;
   logic [NUM_GROUPS-1:0]    rsp_changed_ff, rsp_changed_in;
   logic                     rsp_unsaved_ff, rsp_unsaved_in;

   logic                     tbl_wr_en;
   logic [ADDR_W-1:0]        tbl_wr_addr;
   logic [VALUE_W-1:0]       tbl_wr_data;
   logic                     tbl_rd_en;
   logic [ADDR_W-1:0]        tbl_rd_addr;
   logic [VALUE_W-1:0]       tbl_rd_value;

   avg_ctrl_type             avg_ctrl;
   avg_stat_type             avg_stat;

   logic                     req_xfer;
   logic                     csr_wr;
   logic                     set_ok;
   logic                     get_ok;

   gpt_slot_table u_slots (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_addr  (tbl_wr_addr),
      .wr_data  (tbl_wr_data),
      .rd_en    (tbl_rd_en),
      .rd_addr  (tbl_rd_addr),
      .rd_value (tbl_rd_value)
   );

   gpt_avg_unit u_avg (
      .clock (clock),
      .reset (reset),
      .ctrl  (avg_ctrl),
      .stat  (avg_stat)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_ADDR_W-1] == REG_USED_MASK);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_USED_MASK) ? mask_ff : '0;

   assign set_ok = (req_group != '0) && (req_member != '0) &&
                   (int'(req_member) <= LAST_MEMBER);
   assign get_ok = (req_group != '0) && (int'(req_member) < GROUP_SLOTS);

   // A slot read in the previous cycle counts only if it is in use and its
   // member is enabled in the mask.
   assign avg_ctrl.clear = (state_ff == ST_WRITE);
   assign avg_ctrl.acc   = acc_pend_ff && (tbl_rd_value != MEMBER_EMPTY) &&
                           mask_ff[{group_ff, acc_member_ff}];
   assign avg_ctrl.value = tbl_rd_value;
   assign avg_ctrl.start = (state_ff == ST_DIV_GO);

   always_comb begin
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = {group_ff, member_ff};
      tbl_wr_data = pct_ff;
      tbl_rd_en   = 1'b0;
      tbl_rd_addr = {group_ff, {SLOT_W{1'b0}}};

      case (state_ff)
         ST_WRITE: begin
            tbl_wr_en = 1'b1;
         end
         ST_WALK: begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = {group_ff, walk_ff};
         end
         ST_DIV: begin
            tbl_wr_en   = avg_stat.done;
            tbl_wr_addr = {group_ff, {SLOT_W{1'b0}}};
            tbl_wr_data = avg_stat.average;
         end
         ST_GET_RD: begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = {group_ff, member_ff};
         end
         ST_GET_WAIT, ST_AVG_RD: begin
            tbl_rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      group_in       = group_ff;
      member_in      = member_ff;
      pct_in         = pct_ff;
      walk_in        = walk_ff;
      acc_pend_in    = 1'b0;
      acc_member_in  = acc_member_ff;
      mask_in        = csr_wr ? csr_pwdata : mask_ff;
      dirty_in       = dirty_ff;
      pos_in         = pos_ff;
      avg_in         = avg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_pos_in     = rsp_pos_ff;
      rsp_avg_in     = rsp_avg_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_unsaved_in = rsp_unsaved_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in   = req_mode;
               group_in  = req_group;
               member_in = req_member;
               pct_in    = (req_percent > PCT_MAX) ? PCT_MAX : req_percent;
               pos_in    = POS_NONE;
               case (req_mode)
                  MODE_SET: state_in = set_ok ? ST_WRITE : ST_AVG_RD;
                  MODE_GET: state_in = get_ok ? ST_GET_RD : ST_AVG_RD;
                  default:  state_in = ST_AVG_RD;
               endcase
            end
         end
         ST_WRITE: begin
            walk_in  = SLOT_W'(1);
            state_in = ST_WALK;
         end
         ST_WALK: begin
            acc_pend_in   = 1'b1;
            acc_member_in = walk_ff;
            walk_in       = walk_ff + SLOT_W'(1);
            if (walk_ff == SLOT_W'(LAST_MEMBER)) begin
               state_in = ST_WALK_END;
            end
         end
         ST_WALK_END: begin
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (avg_stat.done) begin
               avg_in   = avg_stat.average;
               pos_in   = signed'({1'b0, pct_ff});
               dirty_in = dirty_ff | (NUM_GROUPS'(1) << group_ff);
               state_in = ST_DONE;
            end
         end
         ST_GET_RD: begin
            state_in = ST_GET_WAIT;
         end
         ST_GET_WAIT: begin
            if (tbl_rd_value != MEMBER_EMPTY) begin
               pos_in = signed'({1'b0, tbl_rd_value});
            end
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_RD: begin
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            avg_in   = tbl_rd_value;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_pos_in     = pos_ff;
               rsp_avg_in     = avg_ff;
               rsp_changed_in = dirty_ff;
               if (mode_ff == MODE_TAKE) begin
                  dirty_in       = '0;
                  rsp_unsaved_in = 1'b0;
               end else begin
                  rsp_unsaved_in = (dirty_ff != '0);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_pend_ff  <= 1'b0;
         mask_ff      <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_pend_ff  <= acc_pend_in;
         mask_ff      <= mask_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      group_ff       <= group_in;
      member_ff      <= member_in;
      pct_ff         <= pct_in;
      walk_ff        <= walk_in;
      acc_member_ff  <= acc_member_in;
      pos_ff         <= pos_in;
      avg_ff         <= avg_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_avg_ff     <= rsp_avg_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_unsaved_ff <= rsp_unsaved_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_out   = rsp_pos_ff;
   assign rsp_group_average  = rsp_avg_ff;
   assign rsp_changed_groups = rsp_changed_ff;
   assign rsp_unsaved        = rsp_unsaved_ff;

   // The block stays busy with an item right after each transfer, so req_ready falls.
   `GPT_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // Unsaved changes are always reflected in the reported mask.
   `GPT_ASSERT_IMP(a_unsaved_mask, clock, reset, rsp_valid && rsp_unsaved, rsp_changed_groups != '0)
   // The member-empty marker never leaves the block as a position.
   `GPT_ASSERT_IMP(a_no_empty_pos, clock, reset, rsp_valid, rsp_position_out != signed'({1'b0, MEMBER_EMPTY}))
   // A group average is a percentage or the group-empty marker.
   `GPT_ASSERT_IMP(a_avg_range, clock, reset, rsp_valid, rsp_group_average <= GROUP_EMPTY)

endmodule

[design/gpt_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/gpt_slot_table.sv]
// ----------------------------------------------------------------------------
// Group position table: slot store
// Slot RAM with a valid bit per entry; an entry never written reads as its
// reset value (group empty for the average slot, member empty otherwise).
// ----------------------------------------------------------------------------
module gpt_slot_table import gpt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [VALUE_W-1:0] rd_value
);

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] valid_in;
   logic                   rd_valid_ff;
   logic                   rd_avg_ff;
   logic [VALUE_W-1:0]     ram_data;

   gpt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
         rd_avg_ff   <= (rd_addr[SLOT_W-1:0] == '0);
      end
   end

   assign rd_value = rd_valid_ff ? ram_data : (rd_avg_ff ? GROUP_EMPTY : MEMBER_EMPTY);

endmodule

[design/gpt_avg_unit.sv]
// ----------------------------------------------------------------------------
// Group position table: averaging unit
// Accumulates member positions one per cycle, then divides the sum by the
// count with a restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gpt_avg_unit import gpt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  avg_ctrl_type ctrl,
   output avg_stat_type stat
);

   logic [SUM_W-1:0]  sum_ff,  sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rem_ff,  rem_in;
   logic [SUM_W-1:0]  quo_ff,  quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              empty_ff, empty_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [CNT_W:0]    rem_shift;
   logic [CNT_W:0]    rem_sub;
   logic              fits;

   // The dividend shifts out at the top while quotient bits shift in below.
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign fits      = (rem_shift >= {1'b0, count_ff});
   assign rem_sub   = rem_shift - {1'b0, count_ff};

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      empty_in = empty_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (ctrl.clear) begin
         sum_in   = '0;
         count_in = '0;
      end else if (ctrl.acc) begin
         sum_in   = sum_ff + SUM_W'(ctrl.value);
         count_in = count_ff + CNT_W'(1);
      end

      if (ctrl.start) begin
         empty_in = (count_ff == '0);
         quo_in   = sum_ff;
         rem_in   = '0;
         step_in  = '0;
         if (count_ff == '0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      empty_ff <= empty_in;
   end

   assign stat.busy    = busy_ff;
   assign stat.done    = done_ff;
   assign stat.average = empty_ff ? GROUP_EMPTY : quo_ff[VALUE_W-1:0];

endmodule
